>>> src/gcwf_pkg.sv
// Shared types, constants and the opcode length table for the command word framer.
package gcwf_pkg;

	localparam int unsigned POS_W = 19;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [31:0] TERM_MASK  = 32'hf000f000;
	localparam logic [31:0] TERM_MATCH = 32'h50005000;
	localparam logic [9:0]  IMG_W_MASK = 10'h3ff;
	localparam logic [8:0]  IMG_H_MASK = 9'h1ff;

	localparam logic [7:0] OP_LINE_A = 8'h48;
	localparam logic [7:0] OP_LINE_B = 8'h58;
	localparam logic [7:0] OP_IMAGE  = 8'ha0;
	localparam logic [7:0] OP_COPY   = 8'hc0;
	localparam logic [7:0] OP_FILL   = 8'h02;

	localparam logic [POS_W-1:0] LINE_A_MIN = 19'd4;
	localparam logic [POS_W-1:0] LINE_B_MIN = 19'd5;
	localparam logic [POS_W-1:0] COPY_LEN   = 19'd3;
	localparam logic [POS_W-1:0] IMG_HDR    = 19'd3;
	localparam logic [POS_W-1:0] IMG_SIZE_POS = 19'd2;

	typedef enum logic [1:0] {
		KIND_FIXED = 2'd0,
		KIND_POLY  = 2'd1,
		KIND_IMAGE = 2'd2
	} length_kind_t;

	typedef struct packed {
		logic [31:0] command_word;
		logic        buffer_end;
	} in_item_t;

	typedef struct packed {
		logic             is_header;
		logic [7:0]       command_opcode;
		logic [POS_W-1:0] word_position;
		logic             command_end;
		logic             truncated;
	} out_item_t;

	typedef struct packed {
		length_kind_t     kind;
		logic [POS_W-1:0] length;
	} hdr_info_t;

	function automatic logic [3:0] table_length(input logic [7:0] op);
		logic [3:0] len;
		if (op == OP_FILL)    len = 4'd3;
		else if (op < 8'h20)  len = 4'd1;
		else if (op < 8'h24)  len = 4'd4;
		else if (op < 8'h28)  len = 4'd7;
		else if (op < 8'h2c)  len = 4'd5;
		else if (op < 8'h30)  len = 4'd9;
		else if (op < 8'h34)  len = 4'd6;
		else if (op < 8'h38)  len = 4'd9;
		else if (op < 8'h3c)  len = 4'd8;
		else if (op < 8'h40)  len = 4'd12;
		else if (op < 8'h48)  len = 4'd3;
		else if (op < 8'h50)  len = 4'd4;
		else if (op < 8'h58)  len = 4'd4;
		else if (op < 8'h60)  len = 4'd5;
		else if (op < 8'h64)  len = 4'd3;
		else if (op < 8'h68)  len = 4'd4;
		else if (op < 8'h6c)  len = 4'd2;
		else if (op < 8'h70)  len = 4'd3;
		else if (op < 8'h74)  len = 4'd2;
		else if (op < 8'h78)  len = 4'd3;
		else if (op < 8'h7c)  len = 4'd2;
		else if (op < 8'h80)  len = 4'd3;
		else if (op < 8'ha0)  len = 4'd4;
		else                  len = 4'd1;
		return len;
	endfunction

endpackage

>>> src/gcwf_header_decode.sv
// Header opcode decode: length kind and word count of a new command.
module gcwf_header_decode (
	input  logic [7:0]         opcode,
	output gcwf_pkg::hdr_info_t info
);
	import gcwf_pkg::*;

	always_comb begin
		if ((opcode >= OP_LINE_A && opcode < OP_LINE_A + 8'd8) ||
		    (opcode >= OP_LINE_B && opcode < OP_LINE_B + 8'd8)) begin
			info.kind   = KIND_POLY;
			info.length = (opcode < OP_LINE_B) ? LINE_A_MIN : LINE_B_MIN;
		end else if (opcode >= OP_IMAGE && opcode < OP_COPY) begin
			info.kind   = KIND_IMAGE;
			info.length = '0;
		end else if (opcode >= OP_COPY && opcode < OP_COPY + 8'h20) begin
			info.kind   = KIND_FIXED;
			info.length = COPY_LEN;
		end else begin
			info.kind   = KIND_FIXED;
			info.length = POS_W'(table_length(opcode));
		end
	end

endmodule

>>> src/gcwf_frame_core.sv
// Framing state and per-word boundary logic.
module gcwf_frame_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  gcwf_pkg::in_item_t  item,
	output gcwf_pkg::out_item_t result
);
	import gcwf_pkg::*;

	logic             inside_q;
	logic [7:0]       opcode_q;
	length_kind_t     kind_q;
	logic [POS_W-1:0] seen_q;
	logic [POS_W-1:0] expect_q;

	hdr_info_t        hdr;
	logic             header;
	logic [7:0]       op;
	length_kind_t     kind_eff;
	logic [POS_W-1:0] exp_eff;
	logic [POS_W-1:0] pos;
	logic             reached;
	logic             done;
	logic             size_word;
	logic [9:0]       w_m1;
	logic [8:0]       h_m1;
	logic [10:0]      img_w;
	logic [9:0]       img_h;
	logic [20:0]      img_area;
	logic [20:0]      img_half;
	logic [POS_W-1:0] img_len;

	gcwf_header_decode u_decode (
		.opcode(item.command_word[31:24]),
		.info  (hdr)
	);

	always_comb begin
		header   = !inside_q;
		op       = header ? item.command_word[31:24] : opcode_q;
		kind_eff = header ? hdr.kind : kind_q;
		exp_eff  = header ? hdr.length : expect_q;
		if (header)
			pos = '0;
		else if (seen_q == POS_MAX)
			pos = POS_MAX;
		else
			pos = seen_q + 1'b1;
		reached = ({1'b0, pos} + 20'd1) >= {1'b0, exp_eff};

		// Image size sits in word 2: width low half, height high half, each wrapped
		w_m1     = (item.command_word[9:0] - 10'd1) & IMG_W_MASK;
		h_m1     = (item.command_word[24:16] - 9'd1) & IMG_H_MASK;
		img_w    = {1'b0, w_m1} + 11'd1;
		img_h    = {1'b0, h_m1} + 10'd1;
		img_area = 21'(img_w * img_h);
		img_half = (img_area + 21'd1) >> 1;
		img_len  = POS_W'(img_half) + IMG_HDR;

		size_word = 1'b0;
		case (kind_eff)
			KIND_POLY: begin
				done = reached && ((item.command_word & TERM_MASK) == TERM_MATCH);
			end
			KIND_IMAGE: begin
				done      = 1'b0;
				size_word = (pos == IMG_SIZE_POS);
			end
			default: begin
				done = reached;
			end
		endcase

		result.is_header      = header;
		result.command_opcode = op;
		result.word_position  = pos;
		result.command_end    = done;
		result.truncated      = item.buffer_end && !done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			opcode_q <= '0;
			kind_q   <= KIND_FIXED;
			seen_q   <= '0;
			expect_q <= '0;
		end else if (advance) begin
			inside_q <= !(done || item.buffer_end);
			opcode_q <= op;
			seen_q   <= pos;
			// once the image size is known the rest counts as a fixed length
			kind_q   <= size_word ? KIND_FIXED : kind_eff;
			expect_q <= size_word ? img_len : exp_eff;
		end
	end

endmodule

>>> src/gpu_command_word_framer.sv
// GPU command word framer: input register, framing core and result register.
//
// Takes one command-list word per cycle while word_stall is low and returns one result
// per word: header mark, opcode, position within the command, end and truncation flags.
// A word is registered on entry, framed against the command state while it sits in the
// input register, and loaded into the result register once that register is empty or
// not held by result_stall; result_valid then rises. Sustained rate is one item per
// cycle while result_stall stays low; the framing state (position, length, kind) is fed
// back from its own registers. The input register and result register give two items
// of buffering, so a new word is taken while a finished result waits on result_stall.
module gpu_command_word_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                word_valid,
	output logic                word_stall,
	input  gcwf_pkg::in_item_t  word,
	output logic                result_valid,
	input  logic                result_stall,
	output gcwf_pkg::out_item_t result
);
	import gcwf_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	out_item_t framed;
	logic      out_block;
	logic      advance;
	logic      load;

	assign out_block  = valid_s2 && result_stall;
	assign advance    = valid_s1 && !out_block;
	assign word_stall = valid_s1 && out_block;
	assign load       = word_valid && !word_stall;

	gcwf_frame_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.item   (item_s1),
		.result (framed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!result_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			item_s1 <= word;
		if (advance)
			result_s2 <= framed;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GPU command word framer.
module testbench;
	import gcwf_pkg::*;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      word_valid   = 1'b0;
	logic      word_stall;
	in_item_t  word         = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result;

	int send_idle_pct = 0;
	int rx_stall_pct  = 0;
	int words_sent    = 0;
	int error_count   = 0;

	// predicted result for every word accepted and not yet returned
	out_item_t expected_frames[$];

	// framing state as the block should hold it
	logic             in_cmd   = 1'b0;
	logic [7:0]       cmd_op   = '0;
	length_kind_t     cmd_kind = KIND_FIXED;
	logic [POS_W-1:0] cmd_pos  = '0;
	logic [POS_W-1:0] cmd_len  = '0;

	gpu_command_word_framer DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word         (word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// word count of fixed-length commands, indexed by opcode / 4
	function automatic logic [POS_W-1:0] fixed_length(input logic [7:0] op);
		logic [POS_W-1:0] len;
		case (op[7:2])
			6'h00: len = (op == OP_FILL) ? 19'd3 : 19'd1;
			6'h08: len = 19'd4;
			6'h09: len = 19'd7;
			6'h0a: len = 19'd5;
			6'h0b: len = 19'd9;
			6'h0c: len = 19'd6;
			6'h0d: len = 19'd9;
			6'h0e: len = 19'd8;
			6'h0f: len = 19'd12;
			6'h10, 6'h11: len = 19'd3;
			6'h12, 6'h13, 6'h14, 6'h15: len = 19'd4;
			6'h16, 6'h17: len = 19'd5;
			6'h18, 6'h1b, 6'h1d, 6'h1f: len = 19'd3;
			6'h19: len = 19'd4;
			6'h1a, 6'h1c, 6'h1e: len = 19'd2;
			6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27: len = 19'd4;
			default: len = 19'd1;
		endcase
		return len;
	endfunction

	// advance the framing state by one word and return the result it gives
	function automatic out_item_t frame_word(input in_item_t it);
		out_item_t  r;
		logic [7:0] op;
		logic [9:0] w_m1;
		logic [8:0] h_m1;
		int         len_i;
		logic       done;
		op = it.command_word[31:24];
		r.is_header = !in_cmd;
		if (!in_cmd) begin
			cmd_op  = op;
			cmd_pos = '0;
			if (op[7:3] == OP_LINE_A[7:3] || op[7:3] == OP_LINE_B[7:3]) begin
				cmd_kind = KIND_POLY;
				cmd_len  = op[4] ? LINE_B_MIN : LINE_A_MIN;
			end else if (op[7:5] == OP_IMAGE[7:5]) begin
				cmd_kind = KIND_IMAGE;
				cmd_len  = '0;
			end else if (op[7:5] == OP_COPY[7:5]) begin
				cmd_kind = KIND_FIXED;
				cmd_len  = COPY_LEN;
			end else begin
				cmd_kind = KIND_FIXED;
				cmd_len  = fixed_length(op);
			end
		end else if (cmd_pos != POS_MAX) begin
			cmd_pos = cmd_pos + 1'b1;
		end
		done = 1'b0;
		case (cmd_kind)
			KIND_POLY: begin
				done = (int'(cmd_pos) + 1 >= int'(cmd_len)) &&
					((it.command_word & TERM_MASK) == TERM_MATCH);
			end
			KIND_IMAGE: begin
				if (cmd_pos == IMG_SIZE_POS) begin
					// sizes wrap: zero means the largest
					w_m1     = it.command_word[9:0] - 10'd1;
					h_m1     = it.command_word[24:16] - 9'd1;
					len_i    = int'(IMG_HDR) + ((int'(w_m1) + 1) * (int'(h_m1) + 1) + 1) / 2;
					cmd_len  = len_i[POS_W-1:0];
					cmd_kind = KIND_FIXED;
				end
			end
			default: done = (int'(cmd_pos) + 1 >= int'(cmd_len));
		endcase
		r.command_opcode = cmd_op;
		r.word_position  = cmd_pos;
		r.command_end    = done;
		r.truncated      = it.buffer_end && !done;
		in_cmd = !(done || it.buffer_end);
		return r;
	endfunction

	task automatic send_word(input logic [31:0] cw, input logic be);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			word_valid <= 1'b0;
			@(negedge clk);
		end
		word_valid <= 1'b1;
		word       <= {cw, be};
		@(posedge clk);
		while (word_stall)
			@(posedge clk);
		expected_frames.push_back(frame_word({cw, be}));
		words_sent++;
	endtask

	// hold input until every pending result is back
	task automatic wait_all_results();
		@(negedge clk);
		word_valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		result_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin : check_result
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_frames.size() == 0) begin
				error_count++;
				if (error_count <= 50)
					$display("%0t: result with no word pending: %h", $time, result);
			end else begin
				want = expected_frames.pop_front();
				if (result.is_header !== want.is_header ||
						result.command_opcode !== want.command_opcode ||
						result.word_position !== want.word_position ||
						result.command_end !== want.command_end ||
						result.truncated !== want.truncated) begin
					error_count++;
					if (error_count <= 50)
						$display({"%0t: mismatch: expected hdr=%b op=%h pos=%0d end=%b trunc=%b,",
							" got hdr=%b op=%h pos=%0d end=%b trunc=%b"}, $time,
							want.is_header, want.command_opcode, want.word_position,
							want.command_end, want.truncated,
							result.is_header, result.command_opcode, result.word_position,
							result.command_end, result.truncated);
				end
			end
		end
	end

	task automatic test_command_lengths();
		send_word(32'h00123456, 1'b0);   // one-word command
		send_word(32'hffffffff, 1'b1);   // one-word command closing a buffer
		send_word(32'h02000000, 1'b0);   // fill: three words
		send_word(32'h00000000, 1'b0);
		send_word(32'hffffffff, 1'b0);
		send_word(32'h48ffffff, 1'b0);   // short poly-line: early terminators ignored
		send_word(32'h55555555, 1'b0);
		send_word(32'h5fff5fff, 1'b0);
		send_word(32'h50005000, 1'b0);
		send_word(32'h5f000000, 1'b0);   // long poly-line ends at position four
		send_word(32'h5aaa5aaa, 1'b0);
		send_word(32'h51115111, 1'b0);
		send_word(32'h52225222, 1'b0);
		send_word(32'h5fff5fff, 1'b0);
		send_word(32'hbfffffff, 1'b0);   // image 2 x 1: four words
		send_word(32'h12345678, 1'b0);
		send_word(32'h00010002, 1'b0);
		send_word(32'ha5a5a5a5, 1'b0);
		send_word(32'hc0000000, 1'b0);   // copy: three words
		send_word(32'h00000001, 1'b0);
		send_word(32'h00000002, 1'b0);
		wait_all_results();
	endtask

	task automatic test_truncation();
		send_word(32'h3c000000, 1'b0);
		send_word(32'h00000000, 1'b1);   // buffer ends mid-command
		send_word(32'h20000000, 1'b1);   // buffer ends on a header
		send_word(32'ha0000000, 1'b0);   // image cut before its size word
		send_word(32'h00000001, 1'b1);
		send_word(32'h01000000, 1'b0);
		wait_all_results();
	endtask

	task automatic send_command();
		logic [7:0]  op;
		logic [31:0] cw;
		logic        last;
		int          n;
		int          extra;
		int          cut;
		case ($urandom_range(3))
			0: op = {($urandom_range(1) != 0) ? OP_LINE_A[7:3] : OP_LINE_B[7:3],
				3'($urandom_range(7))};
			1: op = {($urandom_range(1) != 0) ? OP_IMAGE[7:5] : OP_COPY[7:5], 5'($urandom)};
			default: op = 8'($urandom);
		endcase
		extra = $urandom_range(5);
		cut   = ($urandom_range(9) == 0) ? $urandom_range(8) : -1;
		n     = 0;
		send_word({op, 24'($urandom)}, cut == 0);
		while (in_cmd) begin
			n++;
			cw   = $urandom;
			last = 1'b0;
			case (cmd_kind)
				KIND_POLY: begin
					if (n == int'(cmd_len) - 1 + extra) begin
						cw   = (cw & ~TERM_MASK) | TERM_MATCH;
						last = 1'b1;
					end else if (n < int'(cmd_len) - 1 && $urandom_range(3) == 0) begin
						cw = (cw & ~TERM_MASK) | TERM_MATCH;
					end else if ((cw & TERM_MASK) == TERM_MATCH) begin
						cw[31] = ~cw[31];
					end
				end
				KIND_IMAGE: begin
					// keep images small
					if (n == int'(IMG_SIZE_POS))
						cw = {cw[31:25], 9'($urandom_range(1, 6)), cw[15:10],
							10'($urandom_range(1, 8))};
				end
				default: last = (n + 1 >= int'(cmd_len));
			endcase
			send_word(cw, last ? ($urandom_range(4) == 0) : (n == cut));
		end
	endtask

	// random words, then a buffer end to get back to a header
	task automatic send_noise();
		repeat ($urandom_range(1, 3))
			send_word($urandom, $urandom_range(5) == 0);
		send_word($urandom, 1'b1);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		int limit;
		send_idle_pct = idle_pct;
		rx_stall_pct  = stall_pct;
		limit = words_sent + count;
		while (words_sent < limit) begin
			if ($urandom_range(99) < 15)
				send_noise();
			else
				send_command();
		end
		wait_all_results();
	endtask

	task automatic test_max_image();
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		send_word({OP_IMAGE, 24'($urandom)}, 1'b0);
		send_word($urandom, 1'b0);
		// zero width and height wrap to 1024 x 512; cut the transfer short
		send_word({7'($urandom), 9'h000, 6'($urandom), 10'h000}, 1'b0);
		for (int i = 3; i < 24; i++)
			send_word($urandom, 1'b0);
		send_word($urandom, 1'b1);
		wait_all_results();
	endtask

	task automatic test_endless_polyline();
		logic [31:0] cw;
		send_idle_pct = 0;
		rx_stall_pct  = 0;
		send_word({OP_LINE_B, 24'($urandom)}, 1'b0);
		// run well past the minimum length with no terminator, then terminate
		for (int i = 1; i < 60; i++) begin
			cw = $urandom;
			if ((cw & TERM_MASK) == TERM_MATCH)
				cw[31] = ~cw[31];
			send_word(cw, 1'b0);
		end
		send_word(($urandom & ~TERM_MASK) | TERM_MATCH, 1'b0);
		wait_all_results();
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_command_lengths();
		test_truncation();
		test_random_traffic(0, 0, 350);
		test_random_traffic(48, 0, 350);
		test_random_traffic(0, 48, 350);
		test_random_traffic(38, 38, 350);
		test_max_image();
		test_endless_polyline();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("FAILURE");
		$finish;
	end

endmodule
